// ===== rtl/core/mwm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mwm_pkg;

  localparam int ROWS = 16;
  localparam int COLS = 16;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  localparam int POS_W = 4;

  localparam int HBANK_W = ROW_W - 1 + COL_W;
  localparam int VBANK_W = ROW_W + COL_W - 1;
  localparam int HBANK_DEPTH = 1 << HBANK_W;
  localparam int VBANK_DEPTH = 1 << VBANK_W;

  typedef logic [2:0] op_t;
  typedef logic [1:0] dir_t;
  typedef logic [3:0] walls_t;

  localparam op_t OP_CLEAR = 3'd0;
  localparam op_t OP_SET = 3'd1;
  localparam op_t OP_CHECK = 3'd2;
  localparam op_t OP_SENSE = 3'd3;
  localparam op_t OP_VIEW = 3'd4;
  localparam op_t OP_CORNER = 3'd5;

  localparam dir_t DIR_N = 2'd0;
  localparam dir_t DIR_E = 2'd1;
  localparam dir_t DIR_S = 2'd2;
  localparam dir_t DIR_W = 2'd3;

  typedef struct packed {
    op_t    op;
    logic   a_ok;
    logic   adj;
    dir_t   dir;
    dir_t   heading;
    walls_t set_mask;
    logic   r_top;
    logic   r_bot;
    logic   c_left;
    logic   c_right;
    logic   r_par;
    logic   c_par;
  } stage_t;

endpackage

`default_nettype wire

// ===== rtl/core/maze_wall_map_top.sv =====
// Wall map for a grid of maze cells, four wall bits per cell (N, E, S, W).
// Input channel: a transaction is taken at a rising edge with start high and
// busy low. busy is always low, so one transaction can be taken every cycle.
// Result channel: out_valid is high for exactly one cycle per transaction,
// carrying the result fields; the receiver cannot stall the block.
// The transaction passes through the input register, the stage-2 register and
// the output register, which drives the result fields while out_valid is high.
// Throughput is one transaction per cycle; each transaction reads and writes
// the wall banks in the same cycle.
// Inner walls are kept once each in four 1-bit banks: horizontal walls split
// by row parity and vertical walls split by column parity, so one transaction
// reads and writes each bank at a single address. Border walls are not
// stored; they are generated from the cell position.
// Reset and the clear operation empty all banks, which leaves only the border
// walls. Transactions in flight at reset are dropped.
`timescale 1ns / 1ps
`default_nettype none

module maze_wall_map_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_operation,
  input  wire logic [3:0] in_row_a,
  input  wire logic [3:0] in_col_a,
  input  wire logic [3:0] in_row_b,
  input  wire logic [3:0] in_col_b,
  input  wire logic [1:0] in_heading,
  input  wire logic       in_wall_front,
  input  wire logic       in_wall_left,
  input  wire logic       in_wall_right,
  output logic            out_valid,
  output logic            out_ok,
  output logic            out_wall_present,
  output logic            out_view_front,
  output logic            out_view_left,
  output logic            out_view_right,
  output logic            out_is_corner,
  output logic [3:0]      out_cell_walls
);

  // Input register.
  logic                 in_vld_r;
  mwm_pkg::op_t         op_r;
  logic [3:0]           ra_r, ca_r, rb_r, cb_r;
  mwm_pkg::dir_t        hd_r;
  logic                 wf_r, wl_r, wr_r;

  // Wall banks and their registered read data.
  logic [mwm_pkg::HBANK_DEPTH-1:0] hwall_r [2];
  logic [mwm_pkg::VBANK_DEPTH-1:0] vwall_r [2];
  logic [1:0]                      hrd_r, vrd_r;

  logic                 s2_vld_r;
  mwm_pkg::stage_t      s2_r, s2_nxt;

  logic                 out_vld_r, ok_r, wp_r, vf_r, vl_r, vr_r, corner_r;
  mwm_pkg::walls_t      walls_out_r;

  // Stage 1 decode.
  logic                       a_ok, b_ok, adj;
  mwm_pkg::dir_t              adj_dir;
  mwm_pkg::walls_t            set_mask;
  logic [mwm_pkg::ROW_W-1:0]  row, row_m1, row_bv;
  logic [mwm_pkg::COL_W-1:0]  col, col_m1, col_bv;
  logic                       r_top, r_bot, c_left, c_right;
  logic [mwm_pkg::HBANK_W-1:0] h_addr [2];
  logic [mwm_pkg::VBANK_W-1:0] v_addr [2];
  logic [1:0]                 h_we, v_we;
  logic                       do_clear;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start;
    end
    if (start) begin
      op_r <= in_operation;
      ra_r <= in_row_a;
      ca_r <= in_col_a;
      rb_r <= in_row_b;
      cb_r <= in_col_b;
      hd_r <= in_heading;
      wf_r <= in_wall_front;
      wl_r <= in_wall_left;
      wr_r <= in_wall_right;
    end
  end

  always_comb begin
    a_ok = (32'(ra_r) < mwm_pkg::ROWS) && (32'(ca_r) < mwm_pkg::COLS);
    b_ok = (32'(rb_r) < mwm_pkg::ROWS) && (32'(cb_r) < mwm_pkg::COLS);
    adj = 1'b0;
    adj_dir = mwm_pkg::DIR_N;
    if (a_ok && b_ok) begin
      priority if (ra_r == rb_r && 5'(cb_r) == 5'(ca_r) + 5'd1) begin
        adj = 1'b1;
        adj_dir = mwm_pkg::DIR_E;
      end else if (ra_r == rb_r && 5'(ca_r) == 5'(cb_r) + 5'd1) begin
        adj = 1'b1;
        adj_dir = mwm_pkg::DIR_W;
      end else if (ca_r == cb_r && 5'(rb_r) == 5'(ra_r) + 5'd1) begin
        adj = 1'b1;
        adj_dir = mwm_pkg::DIR_S;
      end else if (ca_r == cb_r && 5'(ra_r) == 5'(rb_r) + 5'd1) begin
        adj = 1'b1;
        adj_dir = mwm_pkg::DIR_N;
      end
    end

    set_mask = '0;
    if (in_vld_r && op_r == mwm_pkg::OP_SET && adj) begin
      set_mask = 4'b0001 << adj_dir;
    end else if (in_vld_r && op_r == mwm_pkg::OP_SENSE && a_ok) begin
      set_mask = (4'(wf_r) << hd_r) | (4'(wl_r) << 2'(hd_r + 2'd3))
               | (4'(wr_r) << 2'(hd_r + 2'd1));
    end
    do_clear = in_vld_r && op_r == mwm_pkg::OP_CLEAR;

    row = ra_r[mwm_pkg::ROW_W-1:0];
    col = ca_r[mwm_pkg::COL_W-1:0];
    row_m1 = row - mwm_pkg::ROW_W'(1);
    col_m1 = col - mwm_pkg::COL_W'(1);
    row_bv = mwm_pkg::ROW_W'(mwm_pkg::ROWS - 1);
    col_bv = mwm_pkg::COL_W'(mwm_pkg::COLS - 1);
    r_top = (row == '0);
    r_bot = (row == row_bv);
    c_left = (col == '0);
    c_right = (col == col_bv);

    for (int b = 0; b < 2; b++) begin
      if (row[0] == b[0]) begin
        h_addr[b] = {row[mwm_pkg::ROW_W-1:1], col};
        h_we[b] = set_mask[mwm_pkg::DIR_S] && !r_bot;
      end else begin
        h_addr[b] = {row_m1[mwm_pkg::ROW_W-1:1], col};
        h_we[b] = set_mask[mwm_pkg::DIR_N] && !r_top;
      end
      if (col[0] == b[0]) begin
        v_addr[b] = {row, col[mwm_pkg::COL_W-1:1]};
        v_we[b] = set_mask[mwm_pkg::DIR_E] && !c_right;
      end else begin
        v_addr[b] = {row, col_m1[mwm_pkg::COL_W-1:1]};
        v_we[b] = set_mask[mwm_pkg::DIR_W] && !c_left;
      end
    end

    s2_nxt.op = op_r;
    s2_nxt.a_ok = a_ok;
    s2_nxt.adj = adj;
    s2_nxt.dir = adj_dir;
    s2_nxt.heading = hd_r;
    s2_nxt.set_mask = set_mask;
    s2_nxt.r_top = r_top;
    s2_nxt.r_bot = r_bot;
    s2_nxt.c_left = c_left;
    s2_nxt.c_right = c_right;
    s2_nxt.r_par = row[0];
    s2_nxt.c_par = col[0];
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 2; b++) begin
      hrd_r[b] <= hwall_r[b][h_addr[b]];
      vrd_r[b] <= vwall_r[b][v_addr[b]];
    end
    if (!rst_n || do_clear) begin
      for (int b = 0; b < 2; b++) begin
        hwall_r[b] <= '0;
        vwall_r[b] <= '0;
      end
    end else begin
      for (int b = 0; b < 2; b++) begin
        if (h_we[b]) begin
          hwall_r[b][h_addr[b]] <= 1'b1;
        end
        if (v_we[b]) begin
          vwall_r[b][v_addr[b]] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= in_vld_r;
    end
    s2_r <= s2_nxt;
  end

  // Stage 2: assemble the cell walls after this transaction and the result flags.
  mwm_pkg::walls_t border, walls;
  logic            ok_nxt, wp_nxt, vf_nxt, vl_nxt, vr_nxt, corner_nxt;

  always_comb begin
    border = {s2_r.c_left, s2_r.r_bot, s2_r.c_right, s2_r.r_top};
    if (s2_r.op == mwm_pkg::OP_CLEAR) begin
      walls = border;
    end else begin
      walls = border | s2_r.set_mask
            | {vrd_r[~s2_r.c_par], hrd_r[s2_r.r_par], vrd_r[s2_r.c_par], hrd_r[~s2_r.r_par]};
    end

    ok_nxt = 1'b0;
    wp_nxt = 1'b0;
    vf_nxt = 1'b0;
    vl_nxt = 1'b0;
    vr_nxt = 1'b0;
    corner_nxt = 1'b0;
    unique case (s2_r.op)
      mwm_pkg::OP_CLEAR: begin
        ok_nxt = 1'b1;
      end
      mwm_pkg::OP_SET: begin
        ok_nxt = s2_r.adj;
      end
      mwm_pkg::OP_CHECK: begin
        ok_nxt = s2_r.adj;
        wp_nxt = s2_r.adj && walls[s2_r.dir];
      end
      mwm_pkg::OP_SENSE: begin
        ok_nxt = s2_r.a_ok;
      end
      mwm_pkg::OP_VIEW: begin
        ok_nxt = s2_r.a_ok;
        vf_nxt = s2_r.a_ok && walls[s2_r.heading];
        vl_nxt = s2_r.a_ok && walls[2'(s2_r.heading + 2'd3)];
        vr_nxt = s2_r.a_ok && walls[2'(s2_r.heading + 2'd1)];
      end
      mwm_pkg::OP_CORNER: begin
        ok_nxt = s2_r.a_ok;
        corner_nxt = s2_r.a_ok
                   && (walls[mwm_pkg::DIR_N] || walls[mwm_pkg::DIR_S])
                   && (walls[mwm_pkg::DIR_E] || walls[mwm_pkg::DIR_W]);
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= s2_vld_r;
    end
    ok_r <= ok_nxt;
    wp_r <= wp_nxt;
    vf_r <= vf_nxt;
    vl_r <= vl_nxt;
    vr_r <= vr_nxt;
    corner_r <= corner_nxt;
    walls_out_r <= s2_r.a_ok ? walls : '0;
  end

  assign out_valid = out_vld_r;
  assign out_ok = ok_r;
  assign out_wall_present = wp_r;
  assign out_view_front = vf_r;
  assign out_view_left = vl_r;
  assign out_view_right = vr_r;
  assign out_is_corner = corner_r;
  assign out_cell_walls = walls_out_r;

endmodule

`default_nettype wire
